/* rtl/ssd_pkg.sv */
// Shared types and constants for the descending selection sorter.
// No dependencies; imported by ssd_mem, selection_sort_descending and ssd_check.
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SCORE_W     = 32;
  localparam int PAYLOAD_W   = 16;
  localparam int DATA_W      = SCORE_W + PAYLOAD_W;

  // One stored entry; the key sits in the low bits, as on the stream.
  typedef struct packed {
    logic [PAYLOAD_W-1:0]      payload;
    logic signed [SCORE_W-1:0] key;
  } entry_t;

  // Write port of the entry store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

endpackage

/* rtl/selection_sort_descending.sv */
// Top level of the descending selection sorter: sequencer, shared key compare.
// Depends on ssd_pkg and instantiates the entry store ssd_mem.
`timescale 1ns / 1ps

// Usage.
// The input channel (in_*) carries one (score, payload) pair per transfer, with
// in_tlast marking the final pair of a list. Up to MAX_ENTRIES pairs are kept;
// further pairs are dropped and every result of that list then has its
// overflow flag set. A last mark on a dropped pair still closes the list.
// While a list is being collected, in_tready is high and each pair takes one
// cycle. After the last pair the block drops in_tready and sorts in place:
// each pass reads the unsorted tail through the single shared key comparator,
// one compare per cycle as the store streams out one entry per cycle, and
// then swaps the largest entry found to the head of that tail.
// The sorted list then leaves on the output channel (out_*), largest score
// first, the next result being read from the store only once the receiver has
// taken the last one; the result stays unchanged in the output register while
// stalled. out_tlast marks the final result, after which the block is ready
// for the next list. Reset (rst_n low, synchronous) empties the list and the
// overflow flag; the store contents need no clearing since only entries of
// the current list are ever read.

module selection_sort_descending (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ssd_pkg::DATA_W-1:0]  in_tdata,   // score [31:0], payload [47:32]
  input  logic                        in_tlast,   // last
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ssd_pkg::DATA_W-1:0]  out_tdata,  // sorted_score [31:0], sorted_payload [47:32]
  output logic                        out_tlast,  // last_out
  output logic                        out_tuser   // overflowed
);
  import ssd_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_HEAD,
    S_SCAN,
    S_SWAP1,
    S_SWAP2,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              drop_r, drop_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [ADDR_W-1:0] tag_r, tag_nxt;
  logic [ADDR_W-1:0] best_idx_r, best_idx_nxt;
  entry_t            best_r, best_nxt;
  entry_t            head_r, head_nxt;
  logic              out_valid_r, out_valid_nxt;
  entry_t            out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_user_r, out_user_nxt;

  mem_wr_t           wr;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  entry_t            in_entry;
  logic [CNT_W-1:0]  n_m1;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  i_inc;
  logic              stored;
  logic              key_gt;

  ssd_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_entry.key     = in_tdata[SCORE_W-1:0];
  assign in_entry.payload = in_tdata[DATA_W-1:SCORE_W];

  assign n_m1      = n_r - CNT_W'(1);
  assign count_inc = count_r + CNT_W'(1);
  assign i_inc     = i_r + CNT_W'(1);
  assign stored    = (count_r < CNT_W'(MAX_ENTRIES));

  // The one shared comparator: is the entry just read strictly greater than the best?
  assign key_gt = (rd_data.key > best_r.key);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    tag_nxt       = tag_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    wr            = '0;
    rd_addr       = '0;

    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          if (stored) begin
            wr.en     = 1'b1;
            wr.addr   = count_r[ADDR_W-1:0];
            wr.data   = in_entry;
            count_nxt = count_inc;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            n_nxt = stored ? count_inc : count_r;
            i_nxt = '0;
            k_nxt = '0;
            if (n_nxt >= CNT_W'(2)) begin
              state_nxt = S_HEAD;
            end else begin
              state_nxt = S_EMIT_RD;
            end
          end
        end
      end

      S_HEAD: begin
        rd_addr   = i_r[ADDR_W-1:0];
        tag_nxt   = i_r[ADDR_W-1:0];
        j_nxt     = i_inc;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        // Read data belongs to the address issued in the previous cycle (tag_r).
        rd_addr = j_r[ADDR_W-1:0];
        tag_nxt = j_r[ADDR_W-1:0];
        j_nxt   = j_r + CNT_W'(1);
        if (tag_r == i_r[ADDR_W-1:0]) begin
          head_nxt     = rd_data;
          best_nxt     = rd_data;
          best_idx_nxt = tag_r;
        end else if (key_gt) begin
          best_nxt     = rd_data;
          best_idx_nxt = tag_r;
        end
        if (tag_r == n_m1[ADDR_W-1:0]) begin
          state_nxt = S_SWAP1;
        end
      end

      S_SWAP1: begin
        // When the head was already the best, both writes put back the same entry.
        wr.en     = 1'b1;
        wr.addr   = i_r[ADDR_W-1:0];
        wr.data   = best_r;
        state_nxt = S_SWAP2;
      end

      S_SWAP2: begin
        wr.en   = 1'b1;
        wr.addr = best_idx_r;
        wr.data = head_r;
        i_nxt   = i_inc;
        if ((i_inc + CNT_W'(1)) < n_r) begin
          state_nxt = S_HEAD;
        end else begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end
      end

      S_EMIT_RD: begin
        rd_addr   = k_r[ADDR_W-1:0];
        state_nxt = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_data;
        out_last_nxt  = (k_r == n_m1);
        out_user_nxt  = drop_r;
        state_nxt     = S_EMIT_WAIT;
      end

      S_EMIT_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    tag_r      <= tag_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    head_r     <= head_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

/* rtl/ssd_mem.sv */
// Entry store of the sorter: one write port, one read port with registered data.
// Depends on ssd_pkg for the entry and write-port types.
`timescale 1ns / 1ps

module ssd_mem (
  input  logic                      clk,
  input  ssd_pkg::mem_wr_t          wr,
  input  logic [ssd_pkg::ADDR_W-1:0] rd_addr,
  output ssd_pkg::entry_t           rd_data
);
  import ssd_pkg::*;

  entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/ssd_check.sv */
// Port-level checks for the descending selection sorter, bound to its top level.
// Depends on ssd_pkg for the data width; sees the top-level ports only.
`timescale 1ns / 1ps

module ssd_check (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [ssd_pkg::DATA_W-1:0] in_tdata,
  input logic                       in_tlast,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ssd_pkg::DATA_W-1:0] out_tdata,
  input logic                       out_tlast,
  input logic                       out_tuser
);
  import ssd_pkg::*;

  // A stalled result holds its whole content.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // Collecting and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  // After the final result of a list the block is back to collecting.
  a_end_of_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("block not ready after the end of a list");

  // Reset leaves the block empty and ready.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // The overflow flag stays the same throughout one emitted list.
  a_flag_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !out_tvalid ##2 out_tuser == $past(out_tuser, 3))
    else $error("overflow flag changed inside a list");

endmodule

bind selection_sort_descending ssd_check u_ssd_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
